FILE: rtl/core/jack_source_tokenizer_macros.svh
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef JACK_SOURCE_TOKENIZER_MACROS_SVH
`define JACK_SOURCE_TOKENIZER_MACROS_SVH

// Condition must hold at every edge outside reset
`define JST_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define JST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define JST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/jst_pkg.sv
// Shared types, constants and helper functions for the Jack tokenizer.
// No dependencies; used by every module of the block.
package jst_pkg;

    localparam int WORD_MAX_DEF = 32;
    localparam int LEN_W        = 6;
    localparam int KW_NUM       = 21;
    localparam int KW_CHARS     = 12;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    typedef enum logic [2:0] {
        CL_KEYWORD = 3'd0,
        CL_SYMBOL  = 3'd1,
        CL_IDENT   = 3'd2,
        CL_INT     = 3'd3,
        CL_STRING  = 3'd4
    } t_class;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_WORD  = 4'd1,
        M_NUM   = 4'd2,
        M_STR   = 4'd3,
        M_LINE  = 4'd4,
        M_BLOCK = 4'd5,
        M_BSTAR = 4'd6
    } t_mode;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_FETCH = 2'd1,
        B_EMIT  = 2'd2
    } t_bstate;

    // One output beat
    typedef struct packed {
        t_class      cls;
        logic [7:0]  ch;
        logic        present;
        logic        last;
        logic [4:0]  kwi;
        logic        trunc;
    } t_item;

    // Queue entry: a single beat, or a buffered word to be read out
    typedef struct packed {
        t_item             item;
        logic              is_word;
        logic [LEN_W-1:0]  len;
    } t_op;

    typedef struct packed {
        logic [1:0] num;
        t_op        op0;
        t_op        op1;
    } t_push;

    typedef struct packed {
        logic word_busy;
        logic idle;
    } t_front_stat;

    // Keyword text, right-justified, and lengths, in keyword index order
    localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_NUM] = '{
        "class", "method", "function", "constructor", "int", "boolean", "char",
        "void", "var", "static", "field", "let", "do", "if", "else", "while",
        "return", "true", "false", "null", "this"
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd5, 4'd6, 4'd8, 4'd11, 4'd3, 4'd7, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5,
        4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd4, 4'd4
    };

    localparam t_op OP_NONE = '{
        item: '{cls: CL_SYMBOL, ch: 8'd0, present: 1'b0, last: 1'b0,
                kwi: 5'd0, trunc: 1'b0},
        is_word: 1'b0, len: '0
    };

    // Character p of keyword k (p below the keyword length)
    function automatic logic [7:0] kw_byte(input int k, input logic [3:0] p);
        logic [KW_CHARS*8-1:0] s;
        logic [3:0]            pos_back;
        s        = KW_TEXT[k];
        pos_back = KW_LEN[k] - 4'd1 - p;
        return s[pos_back*8 +: 8];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return (c == 8'h7B) || (c == 8'h7D) || (c == 8'h28) || (c == 8'h29) ||
               (c == 8'h5B) || (c == 8'h5D) || (c == 8'h2E) || (c == 8'h2C) ||
               (c == 8'h3B) || (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) ||
               (c == 8'h2F) || (c == 8'h26) || (c == 8'h7C) || (c == 8'h3C) ||
               (c == 8'h3E) || (c == 8'h3D) || (c == 8'h7E);
    endfunction

    // Single-character beat
    function automatic t_op mk_char(input t_class cls, input logic [7:0] ch,
                                    input logic last);
        t_op o;
        o              = OP_NONE;
        o.item.cls     = cls;
        o.item.ch      = ch;
        o.item.present = 1'b1;
        o.item.last    = last;
        return o;
    endfunction

endpackage

FILE: rtl/core/jack_source_tokenizer.sv
// Jack source tokenizer, top level: lexer front, op queue and emitter back.
// Depends on jst_pkg, jst_front, jst_queue, jst_back and the assertion macros.
//
// Usage:
//   Input channel (i_valid / o_stall): one beat per source byte (i_kind = 0)
//   or an end-of-text marker (i_kind = 1) that flushes any pending token.
//   Output channel (o_valid / i_stall): one beat per token character; the last
//   beat of a token has o_token_end set, an empty string is a single beat with
//   o_char_present low.
//   Path: a beat enters the op queue when its byte is accepted and from there moves
//   to the output register; a second beat queued by the same byte follows it.
//   Throughput: one input byte per cycle while the four-entry op queue has room
//   for two ops and no word is being read out. A finished word is read out of the
//   word store character by character, each by a store read and then an output
//   load; input is held off from the word flush until its last character is loaded.
//   Receiver stall: the output register holds its beat, the queue fills and the
//   input side stalls once fewer than two queue entries are free.
//   Reset (synchronous, active low): lexer idle, queue empty, no output beat;
//   the word store needs no clearing, only written entries are read.
module jack_source_tokenizer #(
    parameter int WORD_MAX = jst_pkg::WORD_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_source_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_token_class,
    output logic [7:0] o_token_char,
    output logic       o_char_present,
    output logic       o_token_end,
    output logic [4:0] o_keyword_index,
    output logic       o_word_truncated
);

`include "jack_source_tokenizer_macros.svh"

    localparam int AW = $clog2(WORD_MAX);

    jst_pkg::t_push                q_push;
    jst_pkg::t_op                  q_head;
    logic [jst_pkg::QCNT_W-1:0]    q_count;
    logic                          q_pop;
    logic                          word_done;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [7:0]                    wr_data;
    jst_pkg::t_front_stat          f_stat;

    jst_front #(.WORD_MAX(WORD_MAX)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_source_byte (i_source_byte),
        .i_q_count     (q_count),
        .i_word_done   (word_done),
        .o_push        (q_push),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_stat        (f_stat)
    );

    jst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_count (q_count)
    );

    jst_back #(.WORD_MAX(WORD_MAX)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr_en          (wr_en),
        .i_wr_addr        (wr_addr),
        .i_wr_data        (wr_data),
        .i_head           (q_head),
        .i_q_count        (q_count),
        .o_pop            (q_pop),
        .o_word_done      (word_done),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_token_class    (o_token_class),
        .o_token_char     (o_token_char),
        .o_char_present   (o_char_present),
        .o_token_end      (o_token_end),
        .o_keyword_index  (o_keyword_index),
        .o_word_truncated (o_word_truncated)
    );

    // Checks
    `JST_ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n,
                       q_count <= jst_pkg::QCNT_W'(jst_pkg::QUEUE_DEPTH), "op queue overfilled")
    `JST_ASSERT_IMP(a_word_pop_busy, i_clk, i_rst_n, q_pop && q_head.is_word,
                    f_stat.word_busy, "word op popped while front not holding the word store")
    `JST_ASSERT_IMP(a_no_write_busy, i_clk, i_rst_n, wr_en, !f_stat.word_busy,
                    "word store written while a word is being read out")
    `JST_ASSERT_NXT(a_eot_idle, i_clk, i_rst_n, i_valid && !o_stall && i_kind,
                    f_stat.idle, "lexer not idle after end of text")

endmodule

FILE: rtl/core/jst_queue.sv
// Small op queue between lexer front and emitter back; takes up to two ops per cycle.
// Depends on jst_pkg.
module jst_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  jst_pkg::t_push             i_push,
    input  logic                       i_pop,
    output jst_pkg::t_op               o_head,
    output logic [jst_pkg::QCNT_W-1:0] o_count
);

    localparam int PW = jst_pkg::QPTR_W;
    localparam int CW = jst_pkg::QCNT_W;

    jst_pkg::t_op  r_mem [jst_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_push.num);
            r_rp  <= r_rp + PW'(i_pop);
            r_cnt <= r_cnt + CW'(i_push.num) - CW'(i_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wp] <= i_push.op0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wp + PW'(1)] <= i_push.op1;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

FILE: rtl/core/jst_front.sv
// Lexer front: accepts bytes, tracks comment/string/number/word mode, writes word
// characters to the word store and queues output ops. Depends on jst_pkg.
module jst_front #(
    parameter int WORD_MAX = jst_pkg::WORD_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_kind,
    input  logic [7:0]                    i_source_byte,
    input  logic [jst_pkg::QCNT_W-1:0]    i_q_count,
    input  logic                          i_word_done,
    output jst_pkg::t_push                o_push,
    output logic                          o_wr_en,
    output logic [$clog2(WORD_MAX)-1:0]   o_wr_addr,
    output logic [7:0]                    o_wr_data,
    output jst_pkg::t_front_stat          o_stat
);

    localparam int LW  = $clog2(WORD_MAX + 1);
    localparam int AW  = $clog2(WORD_MAX);
    localparam int KN  = jst_pkg::KW_NUM;
    localparam int LNW = jst_pkg::LEN_W;

    jst_pkg::t_mode r_mode, n_mode;
    logic           r_held, n_held;
    logic           r_pend_valid, n_pend_valid;
    logic [7:0]     r_pend_char, n_pend_char;
    logic [LW-1:0]  r_len, n_len;
    logic           r_ovf, n_ovf;
    logic [KN-1:0]  r_kmask, n_kmask;
    logic           r_busy, n_busy;

    logic           accept;
    logic [7:0]     c;
    logic [KN-1:0]  k_base;
    logic [LW-1:0]  k_pos;
    logic [KN-1:0]  kw_upd;
    logic [KN-1:0]  kw_hit;
    logic           kw_any;
    logic [4:0]     kw_idx;
    jst_pkg::t_op   word_op;
    jst_pkg::t_op   v_op [2];
    logic [1:0]     v_n;
    logic           restart;

    assign c       = i_source_byte;
    assign o_stall = (i_q_count > jst_pkg::QCNT_W'(jst_pkg::QUEUE_DEPTH - 2)) || r_busy;
    assign accept  = i_valid && !o_stall;

    // Keyword candidates: continue the running mask, or start fresh at position 0
    assign k_base = (r_mode == jst_pkg::M_WORD) ? r_kmask : '1;
    assign k_pos  = (r_mode == jst_pkg::M_WORD) ? r_len : '0;

    for (genvar k = 0; k < KN; k++) begin : g_kw
        assign kw_upd[k] = k_base[k] && (k_pos < LW'(jst_pkg::KW_LEN[k])) &&
                           (jst_pkg::kw_byte(k, k_pos[3:0]) == c);
        assign kw_hit[k] = r_kmask[k] && !r_ovf && (r_len == LW'(jst_pkg::KW_LEN[k]));
    end

    // Lowest matching keyword index
    always_comb begin
        kw_idx = '0;
        for (int k = KN - 1; k >= 0; k--) begin
            if (kw_hit[k]) begin
                kw_idx = 5'(k);
            end
        end
    end
    assign kw_any = |kw_hit;

    // Word flush op for the buffered word
    always_comb begin
        word_op              = jst_pkg::OP_NONE;
        word_op.is_word      = 1'b1;
        word_op.len          = LNW'(r_len);
        word_op.item.cls     = kw_any ? jst_pkg::CL_KEYWORD : jst_pkg::CL_IDENT;
        word_op.item.kwi     = kw_any ? kw_idx : 5'd0;
        word_op.item.trunc   = r_ovf;
        word_op.item.present = 1'b1;
    end

    // Lexer next state and queued ops
    always_comb begin
        n_mode       = r_mode;
        n_held       = r_held;
        n_pend_valid = r_pend_valid;
        n_pend_char  = r_pend_char;
        n_len        = r_len;
        n_ovf        = r_ovf;
        n_kmask      = r_kmask;
        n_busy       = i_word_done ? 1'b0 : r_busy;
        v_op[0]      = jst_pkg::OP_NONE;
        v_op[1]      = jst_pkg::OP_NONE;
        v_n          = 2'd0;
        restart      = 1'b0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_len[AW-1:0];
        o_wr_data    = c;

        if (accept) begin
            if (i_kind) begin
                // end of text: flush whatever is pending
                if (r_held) begin
                    v_op[0] = jst_pkg::mk_char(jst_pkg::CL_SYMBOL, jst_pkg::CH_SLASH, 1'b1);
                    v_n     = 2'd1;
                end else begin
                    unique case (r_mode)
                        jst_pkg::M_STR: begin
                            v_op[0] = jst_pkg::mk_char(jst_pkg::CL_STRING, r_pend_char, 1'b1);
                            if (!r_pend_valid) begin
                                v_op[0].item.ch      = 8'd0;
                                v_op[0].item.present = 1'b0;
                            end
                            v_n = 2'd1;
                        end
                        jst_pkg::M_NUM: begin
                            if (r_pend_valid) begin
                                v_op[0] = jst_pkg::mk_char(jst_pkg::CL_INT, r_pend_char, 1'b1);
                                v_n     = 2'd1;
                            end
                        end
                        jst_pkg::M_WORD: begin
                            v_op[0] = word_op;
                            v_n     = 2'd1;
                            n_busy  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                n_mode       = jst_pkg::M_IDLE;
                n_held       = 1'b0;
                n_pend_valid = 1'b0;
                n_len        = '0;
                n_ovf        = 1'b0;
            end else if (r_held) begin
                // resolve the held slash
                n_held = 1'b0;
                if (c == jst_pkg::CH_SLASH) begin
                    n_mode = jst_pkg::M_LINE;
                end else if (c == jst_pkg::CH_STAR) begin
                    n_mode = jst_pkg::M_BLOCK;
                end else begin
                    v_op[0] = jst_pkg::mk_char(jst_pkg::CL_SYMBOL, jst_pkg::CH_SLASH, 1'b1);
                    v_n     = 2'd1;
                    restart = 1'b1;
                end
            end else begin
                unique case (r_mode)
                    jst_pkg::M_LINE: begin
                        if (c == jst_pkg::CH_NL) n_mode = jst_pkg::M_IDLE;
                    end
                    jst_pkg::M_BLOCK: begin
                        if (c == jst_pkg::CH_STAR) n_mode = jst_pkg::M_BSTAR;
                    end
                    jst_pkg::M_BSTAR: begin
                        if (c == jst_pkg::CH_SLASH) begin
                            n_mode = jst_pkg::M_IDLE;
                        end else if (c != jst_pkg::CH_STAR) begin
                            n_mode = jst_pkg::M_BLOCK;
                        end
                    end
                    jst_pkg::M_STR: begin
                        if (c == jst_pkg::CH_QUOTE) begin
                            v_op[0] = jst_pkg::mk_char(jst_pkg::CL_STRING, r_pend_char, 1'b1);
                            if (!r_pend_valid) begin
                                v_op[0].item.ch      = 8'd0;
                                v_op[0].item.present = 1'b0;
                            end
                            v_n          = 2'd1;
                            n_mode       = jst_pkg::M_IDLE;
                            n_pend_valid = 1'b0;
                        end else begin
                            if (r_pend_valid) begin
                                v_op[0] = jst_pkg::mk_char(jst_pkg::CL_STRING, r_pend_char,
                                                           1'b0);
                                v_n     = 2'd1;
                            end
                            n_pend_char  = c;
                            n_pend_valid = 1'b1;
                        end
                    end
                    jst_pkg::M_NUM: begin
                        if (jst_pkg::is_digit(c)) begin
                            v_op[0]     = jst_pkg::mk_char(jst_pkg::CL_INT, r_pend_char, 1'b0);
                            v_n         = 2'd1;
                            n_pend_char = c;
                        end else begin
                            v_op[0] = jst_pkg::mk_char(jst_pkg::CL_INT, r_pend_char, 1'b1);
                            v_n     = 2'd1;
                            restart = 1'b1;
                        end
                    end
                    jst_pkg::M_WORD: begin
                        if (jst_pkg::is_alpha(c) || jst_pkg::is_digit(c) ||
                            (c == jst_pkg::CH_USCORE)) begin
                            if (r_len < LW'(WORD_MAX)) begin
                                o_wr_en = 1'b1;
                                n_len   = r_len + LW'(1);
                                n_kmask = kw_upd;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else begin
                            v_op[0] = word_op;
                            v_n     = 2'd1;
                            n_busy  = 1'b1;
                            restart = 1'b1;
                        end
                    end
                    default: begin
                        restart = 1'b1;
                    end
                endcase
            end

            // start of a new token with the current byte
            if (restart) begin
                n_mode       = jst_pkg::M_IDLE;
                n_len        = '0;
                n_ovf        = 1'b0;
                n_pend_valid = 1'b0;
                if (c == jst_pkg::CH_SLASH) begin
                    n_held = 1'b1;
                end else if (jst_pkg::is_symbol(c)) begin
                    v_op[v_n[0]] = jst_pkg::mk_char(jst_pkg::CL_SYMBOL, c, 1'b1);
                    v_n          = v_n + 2'd1;
                end else if (c == jst_pkg::CH_QUOTE) begin
                    n_mode = jst_pkg::M_STR;
                end else if (jst_pkg::is_digit(c)) begin
                    n_pend_char  = c;
                    n_pend_valid = 1'b1;
                    n_mode       = jst_pkg::M_NUM;
                end else if (jst_pkg::is_alpha(c) || (c == jst_pkg::CH_USCORE)) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = '0;
                    n_len     = LW'(1);
                    n_kmask   = kw_upd;
                    n_mode    = jst_pkg::M_WORD;
                end
            end
        end
    end

    assign o_push.num = v_n;
    assign o_push.op0 = v_op[0];
    assign o_push.op1 = v_op[1];

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= jst_pkg::M_IDLE;
            r_held       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_len        <= '0;
            r_ovf        <= 1'b0;
            r_kmask      <= '0;
            r_busy       <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_held       <= n_held;
            r_pend_valid <= n_pend_valid;
            r_len        <= n_len;
            r_ovf        <= n_ovf;
            r_kmask      <= n_kmask;
            r_busy       <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_char <= n_pend_char;
    end

    assign o_stat.word_busy = r_busy;
    assign o_stat.idle      = (r_mode == jst_pkg::M_IDLE) && !r_held && !r_pend_valid &&
                              (r_len == '0);

endmodule

FILE: rtl/core/jst_back.sv
// Emitter back: pops queued ops, reads buffered words out of the word store and
// drives the output register. Depends on jst_pkg.
module jst_back #(
    parameter int WORD_MAX = jst_pkg::WORD_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [$clog2(WORD_MAX)-1:0]   i_wr_addr,
    input  logic [7:0]                    i_wr_data,
    input  jst_pkg::t_op                  i_head,
    input  logic [jst_pkg::QCNT_W-1:0]    i_q_count,
    output logic                          o_pop,
    output logic                          o_word_done,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_token_class,
    output logic [7:0]                    o_token_char,
    output logic                          o_char_present,
    output logic                          o_token_end,
    output logic [4:0]                    o_keyword_index,
    output logic                          o_word_truncated
);

    localparam int LW  = $clog2(WORD_MAX + 1);
    localparam int AW  = $clog2(WORD_MAX);
    localparam int LNW = jst_pkg::LEN_W;

    jst_pkg::t_bstate r_state, n_state;
    jst_pkg::t_op     r_cur, n_cur;
    logic [LW-1:0]    r_idx, n_idx;
    logic [7:0]       r_rd;
    logic [7:0]       r_store [WORD_MAX];
    logic             r_out_valid;
    jst_pkg::t_item   r_out;

    logic             can_load;
    logic             out_load;
    logic             rd_en;
    logic             last;
    jst_pkg::t_item   out_item;

    assign can_load = !r_out_valid || !i_stall;
    assign last     = (LNW'(r_idx) + LNW'(1)) == r_cur.len;

    // Emitter sequencer
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        o_word_done = 1'b0;
        rd_en       = 1'b0;
        out_load    = 1'b0;
        out_item    = i_head.item;
        unique case (r_state)
            jst_pkg::B_IDLE: begin
                if (i_q_count != '0) begin
                    if (i_head.is_word) begin
                        o_pop   = 1'b1;
                        n_cur   = i_head;
                        n_idx   = '0;
                        n_state = jst_pkg::B_FETCH;
                    end else if (can_load) begin
                        o_pop    = 1'b1;
                        out_load = 1'b1;
                    end
                end
            end
            jst_pkg::B_FETCH: begin
                rd_en   = 1'b1;
                n_state = jst_pkg::B_EMIT;
            end
            jst_pkg::B_EMIT: begin
                out_item      = r_cur.item;
                out_item.ch   = r_rd;
                out_item.last = last;
                if (can_load) begin
                    out_load = 1'b1;
                    if (last) begin
                        o_word_done = 1'b1;
                        n_state     = jst_pkg::B_IDLE;
                    end else begin
                        n_idx   = r_idx + LW'(1);
                        n_state = jst_pkg::B_FETCH;
                    end
                end
            end
            default: begin
                n_state = jst_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jst_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_idx <= n_idx;
    end

    // Word store: one write port from the front, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd <= r_store[r_idx[AW-1:0]];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_item;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_token_class    = r_out.cls;
    assign o_token_char     = r_out.ch;
    assign o_char_present   = r_out.present;
    assign o_token_end      = r_out.last;
    assign o_keyword_index  = r_out.kwi;
    assign o_word_truncated = r_out.trunc;

endmodule
